// ===== hdl/sbl_pkg.sv =====
// ============================================================================
// sbl_pkg - shared types and constants for the 3x3 Sobel edge magnitude block
// Pixel and sum widths, register indexes, window column and gradient sum types.
// ============================================================================
`default_nettype none

package sbl_pkg;

	localparam int PIX_W = 8;     // grey level width
	localparam int CFG_W = 12;    // widest configuration register
	localparam int ROW_W = 12;    // row counter width
	localparam int SUM_W = 10;    // a + 2b + c over three pixels
	localparam int IDX_W = 2;     // configuration register index width

	// first interior row / column and the output ceiling
	localparam int FIRST_INTERIOR = 2;
	localparam int MAG_MAX        = 255;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_EDGE_MODE    = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

	// one window column, top to bottom
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} col_t;

	// 1-2-1 sums that feed the two gradients
	typedef struct packed {
		logic [SUM_W-1:0] left;
		logic [SUM_W-1:0] right;
		logic [SUM_W-1:0] upper;
		logic [SUM_W-1:0] lower;
	} sums_t;

endpackage

`default_nettype wire

// ===== hdl/sbl_ram.sv =====
// ============================================================================
// sbl_ram - generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ============================================================================
`default_nettype none

module sbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sbl_cell.sv =====
// ============================================================================
// sbl_cell - one window column cell
// Holds a three-pixel column and takes its neighbor's column on each shift.
// ============================================================================
`default_nettype none

module sbl_cell
	import sbl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic shift,
	input  wire col_t din,
	output col_t      dout
);

	col_t col_q;

	// column register, shifts with the pixel stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= din;
		end
	end

	assign dout = col_q;

endmodule

`default_nettype wire

// ===== hdl/sbl_grad.sv =====
// ============================================================================
// sbl_grad - gradient magnitude
// |Gx| + |Gy| from the 1-2-1 sums, single-polarity option, saturated to 8 bits.
// ============================================================================
`default_nettype none

module sbl_grad
	import sbl_pkg::*;
(
	input  wire sums_t            sums,
	input  wire logic             edge_mode,
	output logic      [PIX_W-1:0] magnitude
);

	logic [SUM_W-1:0] gx;
	logic [SUM_W-1:0] gy;
	logic [SUM_W:0]   total;

	// horizontal part: right minus left
	always_comb begin
		if (sums.left > sums.right) begin
			gx = edge_mode ? '0 : sums.left - sums.right;
		end else begin
			gx = sums.right - sums.left;
		end
	end

	// vertical part: lower minus upper
	always_comb begin
		if (sums.upper > sums.lower) begin
			gy = edge_mode ? '0 : sums.upper - sums.lower;
		end else begin
			gy = sums.lower - sums.upper;
		end
	end

	// add and clip
	assign total     = {1'b0, gx} + {1'b0, gy};
	assign magnitude = (total > (SUM_W+1)'(MAG_MAX)) ? PIX_W'(MAG_MAX) : total[PIX_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/sobel_3x3_edge_magnitude.sv =====
// ============================================================================
// sobel_3x3_edge_magnitude - 3x3 Sobel edge magnitude over a raster pixel stream
// Two line buffers, a two-cell window column chain and a gradient stage.
// ============================================================================
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  pixel    | pix_valid, pix_ready, pixel, frame_start | in
//  result   | res_valid, res_ready, magnitude,         | out
//           | last_in_frame                            |
//  config   | cfg_we, cfg_index, cfg_data              | in
//
//  One pixel per clock unless a result stalls; the result output is registered.
//  The line buffer read is issued on the accepting edge; the write of the prior
//  beat is forwarded when both hit the same column.
//  Line buffers need no clearing after reset; counters and window reset to zero.
//  A stalled result blocks only beats that carry a result; border beats flow on.
// ============================================================================
`default_nettype none

module sobel_3x3_edge_magnitude
	import sbl_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             pix_valid,
	output logic                  pix_ready,
	input  wire logic [PIX_W-1:0] pixel,
	input  wire logic             frame_start,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output logic      [PIX_W-1:0] magnitude,
	output logic                  last_in_frame,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int LW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

	function automatic logic [SUM_W-1:0] wsum(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
		logic [PIX_W-1:0] c);
		return SUM_W'(a) + SUM_W'({b, 1'b0}) + SUM_W'(c);
	endfunction

	// configuration registers
	logic             edge_mode_q;
	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_mode_q    <= 1'b0;
			frame_width_q  <= CFG_W'(640);
			frame_height_q <= CFG_W'(480);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EDGE_MODE:    edge_mode_q    <= cfg_data[0];
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake chain
	logic v_s1, v_s2, out_valid_q;
	logic prod_s1;
	logic out_free, s2_open, s2_adv, s1_adv, accept;

	assign out_free  = !out_valid_q || res_ready;
	assign s2_open   = !v_s2 || out_free;
	assign s2_adv    = v_s2 && out_free;
	assign s1_adv    = v_s1 && (!prod_s1 || s2_open);
	assign pix_ready = !v_s1 || s1_adv;
	assign accept    = pix_valid && pix_ready;

	// effective frame size
	logic [LW-1:0]    fw_ext, w_eff;
	logic [ROW_W-1:0] h_eff;

	assign fw_ext = LW'(frame_width_q);
	assign w_eff  = (fw_ext == '0) ? LW'(1) :
		(fw_ext > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : fw_ext;
	assign h_eff  = (frame_height_q == '0) ? ROW_W'(1) : ROW_W'(frame_height_q);

	// position of the incoming pixel
	logic [CW-1:0]    col_q, c_cur;
	logic [ROW_W-1:0] row_q, r_cur;
	logic [LW-1:0]    c_ext, c_inc;
	logic [ROW_W:0]   r_inc;
	logic             produce, last_pix;

	assign c_cur = frame_start ? '0 : col_q;
	assign r_cur = frame_start ? '0 : row_q;
	assign c_ext = LW'(c_cur);
	assign c_inc = c_ext + LW'(1);
	assign r_inc = {1'b0, r_cur} + (ROW_W+1)'(1);

	assign produce  = (r_cur >= ROW_W'(FIRST_INTERIOR)) && (c_cur >= CW'(FIRST_INTERIOR)) &&
		(r_cur < h_eff) && (c_ext < w_eff);
	assign last_pix = (r_cur == h_eff - ROW_W'(1)) && (c_ext == w_eff - LW'(1));

	// column and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (c_inc >= w_eff) begin
				col_q <= '0;
				row_q <= (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[ROW_W-1:0];
			end else begin
				col_q <= c_inc[CW-1:0];
				row_q <= r_cur;
			end
		end
	end

	// stage 1: line buffer read data arrives, window shifts
	logic [PIX_W-1:0] pix_s1, fwd_top_s1, fwd_mid_s1;
	logic [CW-1:0]    idx_s1;
	logic             last_s1, fwd_s1;
	logic [PIX_W-1:0] above_rd, two_rd;
	col_t             win [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			prod_s1 <= 1'b0;
			fwd_s1  <= 1'b0;
		end else if (accept) begin
			v_s1    <= 1'b1;
			prod_s1 <= produce;
			fwd_s1  <= v_s1 && (idx_s1 == c_cur);
		end else if (s1_adv) begin
			v_s1    <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= pixel;
			idx_s1     <= c_cur;
			last_s1    <= last_pix;
			fwd_top_s1 <= win[0].mid;
			fwd_mid_s1 <= pix_s1;
		end
	end

	// current column, with the prior beat's write forwarded
	assign win[0].top = fwd_s1 ? fwd_top_s1 : two_rd;
	assign win[0].mid = fwd_s1 ? fwd_mid_s1 : above_rd;
	assign win[0].bot = pix_s1;

	sbl_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_above (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (idx_s1),
		.wdata (pix_s1),
		.re    (accept),
		.raddr (c_cur),
		.rdata (above_rd)
	);

	sbl_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_two_above (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (idx_s1),
		.wdata (win[0].mid),
		.re    (accept),
		.raddr (c_cur),
		.rdata (two_rd)
	);

	// window column chain: win[1] is column c-1, win[2] column c-2
	for (genvar i = 1; i < 3; i++) begin : g_cell
		sbl_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (s1_adv),
			.din    (win[i-1]),
			.dout   (win[i])
		);
	end

	sums_t sums;

	assign sums.left  = wsum(win[2].top, win[2].mid, win[2].bot);
	assign sums.right = wsum(win[0].top, win[0].mid, win[0].bot);
	assign sums.upper = wsum(win[2].top, win[1].top, win[0].top);
	assign sums.lower = wsum(win[2].bot, win[1].bot, win[0].bot);

	// stage 2: registered sums
	sums_t sums_s2;
	logic  last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_adv && prod_s1) begin
			v_s2 <= 1'b1;
		end else if (s2_adv) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && prod_s1) begin
			sums_s2 <= sums;
			last_s2 <= last_s1;
		end
	end

	logic [PIX_W-1:0] mag_s2;

	sbl_grad u_grad (
		.sums      (sums_s2),
		.edge_mode (edge_mode_q),
		.magnitude (mag_s2)
	);

	// output register
	logic [PIX_W-1:0] mag_q;
	logic             last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			mag_q  <= mag_s2;
			last_q <= last_s2;
		end
	end

	assign res_valid     = out_valid_q;
	assign magnitude     = mag_q;
	assign last_in_frame = last_q;

	// checks
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted beat missing from stage 1");

	a_frame_start_row: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_start |=> (row_q == ROW_W'(0) || row_q == ROW_W'(1)))
		else $error("row counter not restarted by frame start");

	a_result_reaches_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && prod_s1 && s1_adv |=> v_s2)
		else $error("interior beat lost between stage 1 and stage 2");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_free |=> v_s2 && $stable(sums_s2))
		else $error("stage 2 overwritten while output stalled");

endmodule

`default_nettype wire

// ===== sim/sobel_result_checker.sv =====
// ============================================================================
// sobel_result_checker - edge magnitude predictor and result comparator
// Watches the pixel, result and register ports of the Sobel block, keeps its
// own copy of line buffers, window and counters, and compares every result beat
// with the oldest predicted one. Counts failures for the testbench top.
// ============================================================================

module sobel_result_checker
	import sbl_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	input  logic             pix_ready,
	input  logic [PIX_W-1:0] pixel,
	input  logic             frame_start,
	input  logic             res_valid,
	input  logic             res_ready,
	input  logic [PIX_W-1:0] magnitude,
	input  logic             last_in_frame,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output int               fail_count,
	output int               pend_count,
	output int               result_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_CAP = 100;

	typedef struct packed {
		logic [PIX_W-1:0] mag;
		logic             last;
	} edge_result_t;

	// register copies
	logic             mode_single;
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;

	// predictor state
	logic [PIX_W-1:0] above_line     [MAX_WIDTH];
	logic [PIX_W-1:0] two_above_line [MAX_WIDTH];
	col_t             col_m2, col_m1;
	int unsigned      col_cnt, row_cnt;

	edge_result_t expected_edges[$];
	int fails = 0;
	int pend = 0;
	int seen = 0;

	assign fail_count   = fails;
	assign pend_count   = pend;
	assign result_count = seen;

	task automatic report_mismatch(input string what, input int got, input int want);
		fails++;
		if (fails <= PRINT_CAP)
			$display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// one gradient term; in single-edge mode a larger left/upper sum gives zero
	function automatic int unsigned polarity_diff(input int unsigned low_side,
		input int unsigned high_side);
		if (low_side > high_side)
			return mode_single ? 0 : low_side - high_side;
		return high_side - low_side;
	endfunction

	task automatic predict_magnitude(input logic [PIX_W-1:0] pix, input logic fs);
		int unsigned w, h, c, r, i, grad;
		int unsigned left_sum, right_sum, upper_sum, lower_sum;
		col_t cur;
		edge_result_t res;
		w = (width_reg == 0) ? 1 : width_reg;
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		h = (height_reg == 0) ? 1 : height_reg;
		if (fs) begin
			col_cnt = 0;
			row_cnt = 0;
		end
		c = col_cnt;
		r = row_cnt;
		i = (c < MAX_WIDTH) ? c : 0;

		// column c: two rows up, one row up, this pixel; shift the buffers
		cur.top = two_above_line[i];
		cur.mid = above_line[i];
		cur.bot = pix;
		two_above_line[i] = cur.mid;
		above_line[i]     = cur.bot;

		// interior pixel: window centered on (r-1, c-1)
		if (r >= 2 && c >= 2 && r <= h - 1 && c <= w - 1) begin
			left_sum  = col_m2.top + 2 * col_m2.mid + col_m2.bot;
			right_sum = cur.top + 2 * cur.mid + cur.bot;
			upper_sum = col_m2.top + 2 * col_m1.top + cur.top;
			lower_sum = col_m2.bot + 2 * col_m1.bot + cur.bot;
			grad = polarity_diff(left_sum, right_sum) + polarity_diff(upper_sum, lower_sum);
			if (grad > MAG_MAX)
				grad = MAG_MAX;
			res.mag  = grad[PIX_W-1:0];
			res.last = (r == h - 1 && c == w - 1);
			expected_edges.push_back(res);
		end

		col_m2 = col_m1;
		col_m1 = cur;

		// raster counters, frames wrap without frame_start
		if (c + 1 >= w) begin
			col_cnt = 0;
			row_cnt = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_cnt = c + 1;
		end
	endtask

	task automatic check_result();
		edge_result_t want;
		seen++;
		if (expected_edges.size() == 0) begin
			report_mismatch("result beat with none expected", magnitude, -1);
		end else begin
			want = expected_edges.pop_front();
			if (magnitude !== want.mag)
				report_mismatch("magnitude", magnitude, want.mag);
			if (last_in_frame !== want.last)
				report_mismatch("last_in_frame", last_in_frame, want.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_single = 1'b0;
			width_reg   = 12'd640;
			height_reg  = 12'd480;
			for (int k = 0; k < MAX_WIDTH; k++) begin
				above_line[k]     = '0;
				two_above_line[k] = '0;
			end
			col_m2  = '0;
			col_m1  = '0;
			col_cnt = 0;
			row_cnt = 0;
			expected_edges.delete();
		end else begin
			// a result always trails its pixel, so check before predicting
			if (res_valid && res_ready)
				check_result();
			if (pix_valid && pix_ready)
				predict_magnitude(pixel, frame_start);
			if (cfg_we) begin
				case (cfg_index)
					REG_EDGE_MODE:    mode_single = cfg_data[0];
					REG_FRAME_WIDTH:  width_reg   = cfg_data;
					REG_FRAME_HEIGHT: height_reg  = cfg_data;
					default: ;
				endcase
			end
		end
		pend = expected_edges.size();
	end

endmodule

// ===== sim/testbench.sv =====
// ============================================================================
// testbench - stimulus and verdict for the 3x3 Sobel edge magnitude block
// Streams directed and random frames over many register settings and idle
// mixes, with a long output stall; the checker beside the block predicts and
// compares every result beat.
// ============================================================================

module testbench;
	import sbl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_WIDTH   = 2048;
	localparam int SETTLE      = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 50000;
	localparam int CYCLE_LIMIT = 600000;

	localparam logic EDGE_BOTH   = 1'b0;
	localparam logic EDGE_SINGLE = 1'b1;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

	logic             clk;
	logic             arst_n;
	logic             pix_valid;
	logic             pix_ready;
	logic [PIX_W-1:0] pixel;
	logic             frame_start;
	logic             res_valid;
	logic             res_ready;
	logic [PIX_W-1:0] magnitude;
	logic             last_in_frame;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	int fail_count, pend_count, result_count;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_req      = 0;
	int cycle_count   = 0;
	int pixel_beats   = 0;
	int settings_run  = 0;
	logic [PIX_W-1:0] prev_pix = '0;

	sobel_3x3_edge_magnitude #(.MAX_WIDTH(MAX_WIDTH)) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.pix_valid     (pix_valid),
		.pix_ready     (pix_ready),
		.pixel         (pixel),
		.frame_start   (frame_start),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.magnitude     (magnitude),
		.last_in_frame (last_in_frame),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	sobel_result_checker #(.MAX_WIDTH(MAX_WIDTH)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.pix_valid     (pix_valid),
		.pix_ready     (pix_ready),
		.pixel         (pixel),
		.frame_start   (frame_start),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.magnitude     (magnitude),
		.last_in_frame (last_in_frame),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pend_count    (pend_count),
		.result_count  (result_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pend_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		res_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic set_idle(input idle_mode_e mode);
		case (mode)
			IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
			IDLE_SENDER:   begin send_idle_pct = 56; stall_pct = 0;  end
			IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 56; end
			IDLE_BOTH:     begin send_idle_pct = 9;  stall_pct = 9;  end
			default:       begin send_idle_pct = 0;  stall_pct = 0;  end
		endcase
	endtask

	// three back-to-back register writes; block must be idle
	task automatic set_config(input logic mode, input int w, input int h);
		cfg_we    <= 1'b1;
		cfg_index <= REG_EDGE_MODE;
		cfg_data  <= {{(CFG_W-1){1'b0}}, mode};
		@(posedge clk);
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data  <= w[CFG_W-1:0];
		@(posedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data  <= h[CFG_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		settings_run++;
	endtask

	// one pixel beat, with random idle cycles ahead of it
	task automatic send_beat(input logic [PIX_W-1:0] p, input logic fs);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid   <= 1'b1;
		pixel       <= p;
		frame_start <= fs;
		@(posedge clk);
		while (!pix_ready)
			@(posedge clk);
		pixel_beats++;
		prev_pix = p;
	endtask

	task automatic send_row3(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
		input logic [PIX_W-1:0] c, input logic fs);
		send_beat(a, fs);
		send_beat(b, 1'b0);
		send_beat(c, 1'b0);
	endtask

	// stop offering and wait until every predicted result has come back
	task automatic drain();
		int guard;
		guard = 0;
		pix_valid <= 1'b0;
		@(posedge clk);
		while (pend_count != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	// random grey levels: full range, hard black/white edges, or smooth steps
	function automatic logic [PIX_W-1:0] pick_pixel(input logic [PIX_W-1:0] prev);
		int v;
		case ($urandom_range(3))
			0, 1:    v = $urandom_range(255);
			2:       v = $urandom_range(1) ? 255 : 0;
			default: v = int'(prev) + $urandom_range(16) - 8;
		endcase
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[PIX_W-1:0];
	endfunction

	// raster stream; open_frame marks the first beat, noise adds stray frame starts
	task automatic stream_pixels(input int count, input bit open_frame, input int noise_permille);
		logic fs;
		for (int k = 0; k < count; k++) begin
			fs = (k == 0 && open_frame) || ($urandom_range(999) < noise_permille);
			send_beat(pick_pixel(prev_pix), fs);
		end
	endtask

	initial begin
		pix_valid   = 1'b0;
		pixel       = '0;
		frame_start = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_EDGE_MODE;
		cfg_data    = '0;
		arst_n      = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: smallest frame, saturating horizontal edge, both polarities
		set_idle(IDLE_NONE);
		set_config(EDGE_BOTH, 3, 3);
		send_row3(8'd255, 8'd128, 8'd0, 1'b1);
		send_row3(8'd255, 8'd128, 8'd0, 1'b0);
		send_row3(8'd255, 8'd128, 8'd0, 1'b0);
		drain();
		set_config(EDGE_SINGLE, 3, 3);
		send_row3(8'd255, 8'd128, 8'd0, 1'b1);   // falling edge is zeroed
		send_row3(8'd255, 8'd128, 8'd0, 1'b0);
		send_row3(8'd255, 8'd128, 8'd0, 1'b0);
		send_row3(8'd0,   8'd0,   8'd0, 1'b1);   // rising vertical edge saturates
		send_row3(8'd128, 8'd128, 8'd128, 1'b0);
		send_row3(8'd255, 8'd255, 8'd255, 1'b0);
		drain();

		// sizes below three or zero: counters run, no results
		set_config(EDGE_BOTH, 0, 5);    stream_pixels(16, 1, 0); drain();
		set_config(EDGE_BOTH, 1, 4);    stream_pixels(16, 1, 0); drain();
		set_config(EDGE_SINGLE, 2, 3);  stream_pixels(16, 1, 0); drain();
		set_config(EDGE_BOTH, 5, 0);    stream_pixels(16, 1, 0); drain();
		set_config(EDGE_BOTH, 5, 1);    stream_pixels(16, 1, 0); drain();
		set_config(EDGE_SINGLE, 4095, 2); stream_pixels(16, 1, 0); drain();

		// random frames, fixed settings
		set_idle(IDLE_NONE);
		set_config(EDGE_BOTH, 3, 3);
		stream_pixels(150, 1, 5);
		drain();

		set_idle(IDLE_SENDER);
		set_config(EDGE_SINGLE, 7, 5);
		stream_pixels(200, 1, 5);
		drain();

		// long output hold while pixels keep coming: block fills and backs up
		set_idle(IDLE_RECEIVER);
		set_config(EDGE_BOTH, 16, 4);
		stream_pixels(100, 1, 0);
		hold_req++;
		stream_pixels(150, 0, 5);
		drain();

		// tallest frame, only its first rows
		set_idle(IDLE_BOTH);
		set_config(EDGE_SINGLE, 5, 4095);
		stream_pixels(200, 1, 0);
		drain();

		// pause mid-frame until all results are back, then carry on
		set_config(EDGE_BOTH, 32, 6);
		stream_pixels(150, 1, 0);
		drain();
		stream_pixels(150, 0, 5);
		drain();

		// random settings, rotating idle mixes
		for (int p = 0; p < 4; p++) begin
			set_idle(idle_mode_e'(p % 4));
			set_config(1'($urandom_range(1)), $urandom_range(3, 24), $urandom_range(3, 8));
			stream_pixels(120, 1, 7);
			drain();
		end

		$display("Run covered %0d pixel beats over %0d register settings, %0d results compared.",
			pixel_beats, settings_run, result_count);
		$display("Both edge modes, widths 0 to 4095, heights 0 to 4095, idle mixes, long stall.");
		if (pend_count != 0)
			$display("%0d predicted results never arrived", pend_count);
		if (fail_count == 0 && pend_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
